// ===== rtl/tte_pkg.sv =====
package tte_pkg;
    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_ARMED     = 3'd0,
        K_FULL      = 3'd1,
        K_CANCELLED = 3'd2,
        K_MISS      = 3'd3,
        K_EXPIRED   = 3'd4,
        K_IDLE      = 3'd5
    } t_kind;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [31:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {{(TIME_BITS-31){1'b0}}, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction
endpackage

// ===== rtl/timer_table_expiry.sv =====
// Timer table of 16 one-shot or periodic timers. Input beat tdata, low bit up:
// operation[1:0], now_us[47:0], delay_us[31:0], period_us[31:0], target_slot[3:0],
// target_tag[15:0]. Output tdata: kind, slot, tag, periodic, pending_count,
// earliest_due; tlast marks the final result of a beat. Due times, periods and
// tags live in one synchronous memory read one slot per cycle. An arm result
// follows one summary walk of the table, a cancel result one read of the target
// slot and then the summary walk. A tick walks the table once per expired timer,
// once more to find nothing left due (skipped after 16 expiries), then once for
// the pending count and earliest due time; its results then follow one per cycle
// while the output is not stalled. A new input beat is taken only after the
// final result of the previous one has been accepted.
module timer_table_expiry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // op, now, delay, period, tslot, ttag
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // kind, slot, tag, periodic, count, earliest
    output logic         m_axis_tlast
);
    import tte_pkg::*;

    localparam int MW = TIME_BITS + 32 + 16;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EMIT, S_WB, S_SUM, S_OUT, S_FLUSH
    } t_state;

    logic [MW-1:0] mem [SLOTS];
    logic [MW-1:0] r_rd;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [MW-1:0]     wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    t_state              r_state;
    logic [SLOTS-1:0]    r_valid, r_picked;
    logic [15:0]         r_tagc;
    logic [TIME_BITS-1:0] r_now;
    logic [SLOT_W-1:0]   r_tslot;
    logic [15:0]         r_ttag;
    logic [SLOT_W:0]     r_idx;       // address issued, wide to reach SLOTS
    logic [SLOT_W-1:0]   r_pidx;      // address of data now in r_rd
    logic                r_pv;
    logic                r_found;
    logic [SLOT_W-1:0]   r_best;
    logic [TIME_BITS-1:0] r_bdue;
    logic [31:0]         r_bper;
    logic [15:0]         r_btag;
    logic [SLOT_W:0]     r_nemit;
    logic [SLOT_W-1:0]   r_eslot [SLOTS];  // expiries in emit order
    logic [15:0]         r_etag [SLOTS];
    logic [SLOTS-1:0]    r_eper;
    logic [SLOT_W:0]     r_ocur;
    t_kind               r_kind;
    logic [SLOT_W-1:0]   r_oslot;
    logic [15:0]         r_otag;
    logic [CNT_W-1:0]    r_cnt;
    logic [TIME_BITS-1:0] r_early;
    logic                r_any;
    logic                r_ovalid, r_olast;
    logic [79:0]         r_odata;

    logic [TIME_BITS-1:0] rd_due;
    logic [31:0]          rd_per;
    logic [15:0]          rd_tag;
    assign rd_due = r_rd[MW-1 -: TIME_BITS];
    assign rd_per = r_rd[31+16:16];
    assign rd_tag = r_rd[15:0];

    logic [SLOT_W-1:0] free_slot;
    logic              free_any;
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SLOT_W'(i);
                free_any  = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;

    logic              out_exp;
    logic              out_final;
    logic              out_per;
    logic [SLOT_W-1:0] out_slot;
    logic [15:0]       out_tag;
    assign out_exp   = (r_kind == K_EXPIRED);
    assign out_final = !out_exp || ((r_ocur + 1'b1) == r_nemit);
    assign out_slot  = out_exp ? r_eslot[r_ocur[SLOT_W-1:0]] : r_oslot;
    assign out_tag   = out_exp ? r_etag[r_ocur[SLOT_W-1:0]] : r_otag;
    assign out_per   = out_exp && r_eper[r_ocur[SLOT_W-1:0]];

    always_comb begin
        rd_addr = r_idx[SLOT_W-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready
                && t_op'(s_axis_tdata[1:0]) == OP_ARM && free_any) begin
            wr_en   = 1'b1;
            wr_addr = free_slot;
            wr_data = {sat_add(s_axis_tdata[49:2], s_axis_tdata[81:50]),
                       s_axis_tdata[113:82], r_tagc};
        end else if (r_state == S_WB && r_bper != '0) begin
            wr_en   = 1'b1;
            wr_addr = r_best;
            wr_data = {sat_add(r_now, r_bper), r_bper, r_btag};
        end
        if (r_state == S_IDLE) rd_addr = s_axis_tdata[117:114];
    end

    function automatic logic [79:0] pack(t_kind k, logic [SLOT_W-1:0] s,
                                         logic [15:0] t, logic p,
                                         logic [CNT_W-1:0] c,
                                         logic [TIME_BITS-1:0] e);
        return {3'b000, e, c, p, t, s, k};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_tagc    <= 16'd1;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_nemit   <= '0;
        end else begin
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_now    <= s_axis_tdata[49:2];
                        r_tslot  <= s_axis_tdata[117:114];
                        r_ttag   <= s_axis_tdata[133:118];
                        r_picked <= '0;
                        r_nemit  <= '0;
                        r_ocur   <= '0;
                        unique case (t_op'(s_axis_tdata[1:0]))
                            OP_ARM: begin
                                if (free_any) begin
                                    r_valid[free_slot] <= 1'b1;
                                    r_tagc  <= r_tagc + 16'd1;
                                    r_kind  <= K_ARMED;
                                    r_oslot <= free_slot;
                                    r_otag  <= r_tagc;
                                end else begin
                                    r_kind  <= K_FULL;
                                    r_oslot <= '0;
                                    r_otag  <= '0;
                                end
                                r_state <= S_SUM;
                            end
                            OP_CANCEL: r_state <= S_FLUSH;
                            OP_TICK:   r_state <= S_SCAN;
                            OP_NONE:   r_state <= S_IDLE;
                        endcase
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        r_cnt   <= '0;
                        r_any   <= 1'b0;
                        r_early <= '0;
                    end
                end
                S_FLUSH: begin  // cancel: memory word of target is in r_rd
                    r_oslot <= r_tslot;
                    r_otag  <= r_ttag;
                    if (r_valid[r_tslot] && rd_tag == r_ttag) begin
                        r_valid[r_tslot] <= 1'b0;
                        r_kind <= K_CANCELLED;
                    end else begin
                        r_kind <= K_MISS;
                    end
                    r_state <= S_SUM;
                end
                S_SCAN: begin
                    if (r_pv && r_valid[r_pidx] && !r_picked[r_pidx] && rd_due < r_now
                            && (!r_found || rd_due < r_bdue)) begin
                        r_found <= 1'b1;
                        r_best  <= r_pidx;
                        r_bdue  <= rd_due;
                        r_bper  <= rd_per;
                        r_btag  <= rd_tag;
                    end
                    r_pidx <= r_idx[SLOT_W-1:0];
                    r_pv   <= (r_idx != SLOTS[SLOT_W:0]);
                    if (r_idx != SLOTS[SLOT_W:0]) r_idx <= r_idx + 1'b1;
                    else if (!r_pv) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_found) begin
                        r_kind <= K_EXPIRED;
                        r_eslot[r_nemit[SLOT_W-1:0]] <= r_best;
                        r_etag[r_nemit[SLOT_W-1:0]]  <= r_btag;
                        r_eper[r_nemit[SLOT_W-1:0]]  <= (r_bper != '0);
                        r_picked[r_best] <= 1'b1;
                        if (r_bper == '0) r_valid[r_best] <= 1'b0;
                        r_nemit <= r_nemit + 1'b1;
                        r_state <= S_WB;
                    end else begin
                        if (r_nemit == '0) begin
                            r_kind  <= K_IDLE;
                            r_oslot <= '0;
                            r_otag  <= '0;
                        end
                        r_idx <= '0;
                        r_pv  <= 1'b0;
                        r_state <= S_SUM;
                    end
                end
                S_WB: begin
                    r_found <= 1'b0;
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    if (r_nemit == SLOTS[SLOT_W:0]) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SUM: begin
                    if (r_pv && r_valid[r_pidx]) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (!r_any || rd_due < r_early) r_early <= rd_due;
                        r_any <= 1'b1;
                    end
                    r_pidx <= r_idx[SLOT_W-1:0];
                    r_pv   <= (r_idx != SLOTS[SLOT_W:0]);
                    if (r_idx != SLOTS[SLOT_W:0]) r_idx <= r_idx + 1'b1;
                    else if (!r_pv) r_state <= S_OUT;
                end
                S_OUT: begin  // one beat per expiry (one beat otherwise), summary known by now
                    if (out_free) begin
                        r_olast <= out_final;
                        r_odata <= pack(r_kind, out_slot, out_tag, out_per, r_cnt, r_early);
                        r_ocur  <= r_ocur + 1'b1;
                        if (out_final) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE)
        else $error("input taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && out_free && out_final |=> m_axis_tvalid && m_axis_tlast)
        else $error("final beat not flagged");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nemit <= SLOTS[SLOT_W:0])
        else $error("too many expiries");
endmodule

// ===== sim/tb_timer_table_expiry.sv =====
`timescale 1ns / 1ps

module tb_timer_table_expiry;
    import tte_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] tag;
        logic        periodic;
        logic        last;
        logic [4:0]  pending;
        logic [47:0] earliest;
    } t_res;

    // Timer table model and the queue of results it predicts.
    class timer_scoreboard;
        logic        armed [16];
        logic [47:0] due [16];
        logic [31:0] period [16];
        logic [15:0] tags [16];
        logic [15:0] next_tag;
        t_res        pending_q[$];
        int          errors;

        function void clear();
            for (int i = 0; i < 16; i++) begin
                armed[i] = 0;
                due[i] = '0;
                period[i] = '0;
                tags[i] = '0;
            end
            next_tag = 16'd1;
            pending_q.delete();
            errors = 0;
        endfunction

        function logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {17'd0, b};
            return s[48] ? {48{1'b1}} : s[47:0];
        endfunction

        function void note_beat(logic [135:0] d);
            t_op         op;
            logic [47:0] now;
            logic [31:0] dly;
            logic [31:0] per;
            logic [3:0]  ts;
            logic [15:0] tt;
            t_res        r;
            t_res        batch[$];
            logic        picked [16];
            int          best;
            int          cnt;
            logic [47:0] e;
            logic        any;
            op  = t_op'(d[1:0]);
            now = d[49:2];
            dly = d[81:50];
            per = d[113:82];
            ts  = d[117:114];
            tt  = d[133:118];
            r = '0;
            if (op == OP_NONE) return;
            if (op == OP_ARM) begin
                best = -1;
                for (int i = 15; i >= 0; i--) if (!armed[i]) best = i;
                if (best < 0) begin
                    r.kind = K_FULL;
                end else begin
                    armed[best] = 1;
                    due[best] = add_sat(now, dly);
                    period[best] = per;
                    tags[best] = next_tag;
                    next_tag++;
                    r.kind = K_ARMED;
                    r.slot = best[3:0];
                    r.tag = tags[best];
                end
                batch = {batch, r};
            end else if (op == OP_CANCEL) begin
                r.slot = ts;
                r.tag = tt;
                if (armed[ts] && tags[ts] == tt) begin
                    armed[ts] = 0;
                    r.kind = K_CANCELLED;
                end else begin
                    r.kind = K_MISS;
                end
                batch = {batch, r};
            end else begin
                for (int i = 0; i < 16; i++) picked[i] = 0;
                for (int k = 0; k < 16; k++) begin
                    best = -1;
                    for (int i = 0; i < 16; i++)
                        if (armed[i] && !picked[i] && due[i] < now)
                            if (best < 0 || due[i] < due[best]) best = i;
                    if (best < 0) break;
                    picked[best] = 1;
                    r = '0;
                    r.kind = K_EXPIRED;
                    r.slot = best[3:0];
                    r.tag = tags[best];
                    r.periodic = period[best] != 0;
                    batch = {batch, r};
                end
                for (int k = 0; k < batch.size(); k++) begin
                    best = int'(batch[k].slot);
                    if (batch[k].periodic) due[best] = add_sat(now, period[best]);
                    else armed[best] = 0;
                end
                if (batch.size() == 0) begin
                    r = '0;
                    r.kind = K_IDLE;
                    batch = {batch, r};
                end
            end
            cnt = 0;
            any = 0;
            e = '0;
            for (int i = 0; i < 16; i++)
                if (armed[i]) begin
                    cnt++;
                    if (!any || due[i] < e) e = due[i];
                    any = 1;
                end
            for (int k = 0; k < batch.size(); k++) begin
                batch[k].last = (k == batch.size() - 1);
                batch[k].pending = cnt[4:0];
                batch[k].earliest = e;
                pending_q = {pending_q, batch[k]};
            end
        endfunction

        function void check_result(logic [79:0] d, logic lst);
            t_res got;
            t_res exp_r;
            got = '0;
            got.kind = d[2:0];
            got.slot = d[6:3];
            got.tag = d[22:7];
            got.periodic = d[23];
            got.pending = d[28:24];
            got.earliest = d[76:29];
            got.last = lst;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.kind !== exp_r.kind || got.slot !== exp_r.slot || got.tag !== exp_r.tag
                || got.periodic !== exp_r.periodic || got.last !== exp_r.last
                || got.pending !== exp_r.pending || got.earliest !== exp_r.earliest) begin
                $display("%0t: mismatch, expected k%0d s%0d t%h p%0d l%0d c%0d e%h",
                         $time, exp_r.kind, exp_r.slot, exp_r.tag, exp_r.periodic,
                         exp_r.last, exp_r.pending, exp_r.earliest);
                $display("%0t:           actual k%0d s%0d t%h p%0d l%0d c%0d e%h",
                         $time, got.kind, got.slot, got.tag, got.periodic,
                         got.last, got.pending, got.earliest);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tlast;

    timer_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;
    logic timed_out = 0;
    logic [47:0] clock_us = 48'd1000;
    logic [15:0] issued_tags [16];

    always #6 i_clk = ~i_clk;

    timer_table_expiry u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                if (m_axis_tdata[2:0] == K_ARMED)
                    issued_tags[m_axis_tdata[6:3]] <= m_axis_tdata[22:7];
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) timed_out <= 1;
        end
    end

    // tvalid stays up after a taken beat only until the next call or drain()
    task automatic send_beat(t_op op, logic [47:0] now, logic [31:0] dly,
                             logic [31:0] per, logic [3:0] ts, logic [15:0] tt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, tt, ts, per, dly, now, op};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_u32();
        case ($urandom_range(3))
            0: return $urandom_range(40);
            1: return $urandom_range(400);
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_beat();
        int sel;
        logic [3:0] s;
        sel = $urandom_range(99);
        s = 4'($urandom_range(15));
        clock_us = clock_us + $urandom_range(60);
        if (sel < 40)
            send_beat(OP_ARM, clock_us, rand_u32(),
                      ($urandom_range(1) ? rand_u32() : 32'd0), '0, '0);
        else if (sel < 60)
            send_beat(OP_CANCEL, clock_us, $urandom, $urandom, s,
                      $urandom_range(3) != 0 ? issued_tags[s] : 16'($urandom));
        else if (sel < 95)
            send_beat(OP_TICK, clock_us, $urandom, $urandom, 4'($urandom), 16'($urandom));
        else if (sel < 98)
            send_beat(OP_TICK, 48'({$urandom, $urandom}), $urandom, $urandom,
                      4'($urandom), 16'($urandom));
        else
            send_beat(OP_NONE, 48'({$urandom, $urandom}), $urandom, $urandom,
                      4'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear();
        for (int i = 0; i < 16; i++) issued_tags[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        fork
            begin
                recv_stall_pct = 0;
                send_beat(OP_TICK, '0, '0, '0, '0, '0);
                send_beat(OP_CANCEL, '0, '0, '0, 4'd15, 16'hFFFF);
                for (int i = 0; i < 16; i++)
                    send_beat(OP_ARM, 48'd100, 32'(i % 3), (i[0] ? 32'd5 : 32'd0), '0, '0);
                send_beat(OP_ARM, {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
                send_beat(OP_CANCEL, '0, '0, '0, 4'd3, 16'd4);
                send_beat(OP_CANCEL, '0, '0, '0, 4'd5, 16'd1);
                send_beat(OP_NONE, {48{1'b1}}, '1, '1, '1, '1);
                send_beat(OP_TICK, 48'd102, '0, '0, '0, '0);
                send_beat(OP_TICK, {48{1'b1}}, '0, '0, '0, '0);
                send_beat(OP_ARM, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
                send_beat(OP_TICK, {48{1'b1}}, '0, '0, '0, '0);
                drain();
                for (int ph = 0; ph < 4; ph++) begin
                    send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 35) : 0;
                    recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 35) : 0;
                    for (int n = 0; n < 49; n++) random_beat();
                    drain();
                end
            end
            begin
                wait (timed_out);
            end
        join_any
        if (timed_out) begin
            $display("FAIL timer_table_expiry");
        end else if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS timer_table_expiry");
        end else begin
            $display("FAIL timer_table_expiry");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/tte_pkg.sv
rtl/timer_table_expiry.sv
sim/tb_timer_table_expiry.sv
